// ===== hdl/thermal_false_color_rgb565_defines.svh =====
// Assertion macros used by the false-color mapper RTL (the position divider).
`ifndef THERMAL_FALSE_COLOR_RGB565_DEFINES_SVH
`define THERMAL_FALSE_COLOR_RGB565_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TFC_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tfc: assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TFC_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tfc: assertion failed");

`endif

// ===== hdl/tfc_pkg.sv =====
// Types and constants of the false-color mapper.
`default_nettype none
package tfc_pkg;

  localparam int TEMP_W      = 16;
  localparam int COLOR_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int SEG_W       = 3;
  localparam int FRAC_W      = 16;
  localparam int FRAC_STEPS  = 4;
  localparam int FRAC_STAGES = FRAC_W / FRAC_STEPS;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;

  localparam logic signed [TEMP_W-1:0] RANGE_LOW_RESET  = 16'sd2000;
  localparam logic signed [TEMP_W-1:0] RANGE_HIGH_RESET = 16'sd3000;

  localparam logic [SEG_W-1:0]  SEG_LAST = 3'd4;
  localparam logic [SEG_W-1:0]  SEG_MID  = 3'd2;
  localparam logic [FRAC_W:0]   Q_ONE    = 17'd65536;
  localparam logic [FRAC_W:0]   Q_HALF   = 17'd32768;
  localparam logic [19:0]       X3_BASE  = 20'd655360;
  localparam logic [19:0]       X4_BASE  = 20'd458752;
  localparam logic [12:0]       RECIP10  = 13'd6554;
  localparam logic [13:0]       RECIP5   = 14'd13108;

  // How a sample lands on the scale.
  typedef enum logic [1:0] {
    MODE_DIV,
    MODE_ZERO,
    MODE_FULL,
    MODE_MID
  } mode_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] low;
    logic [TEMP_W-1:0]        span;
    logic                     span_ok;
  } range_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [FRAC_W:0]  frac;
  } pos_t;

endpackage
`default_nettype wire

// ===== hdl/tfc_if.sv =====
// Stream and configuration interfaces of the false-color mapper.
`default_nettype none
interface tfc_temp_if import tfc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  modport source (output valid, output temperature, input ready);
  modport sink (input valid, input temperature, output ready);
endinterface

interface tfc_color_if import tfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] rgb565;
  modport source (output valid, output rgb565, input ready);
  modport sink (input valid, input rgb565, output ready);
endinterface

interface tfc_cfg_if import tfc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TEMP_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/tfc_divider.sv =====
// Pipelined position divider: sample to segment and Q1.16 fraction.
`default_nettype none
`include "thermal_false_color_rgb565_defines.svh"
module tfc_divider import tfc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire range_t                   rng,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [TEMP_W-1:0] temperature,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output pos_t                          out_pos
);

  localparam int NST = 2 + FRAC_STAGES;

  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  // Stage 1: offset, range class, 5 * offset.
  mode_t       s1_mode;
  logic [18:0] s1_a;
  // Stage 2: integer segment and remainder.
  mode_t            s2_mode;
  logic [SEG_W-1:0] s2_seg;
  logic [15:0]      s2_rem;
  // Fraction stages.
  mode_t            fr_mode [FRAC_STAGES];
  logic [SEG_W-1:0] fr_seg  [FRAC_STAGES];
  logic [15:0]      fr_rem  [FRAC_STAGES];
  logic [15:0]      fr_frac [FRAC_STAGES];

  mode_t            s1_mode_next;
  logic [18:0]      s1_a_next;
  logic [SEG_W-1:0] s2_seg_next;
  logic [15:0]      s2_rem_next;

  function automatic logic [31:0] frac_step(input logic [15:0] rem_i,
                                            input logic [15:0] span_i,
                                            input logic [15:0] frac_i);
    logic [15:0] r;
    logic [15:0] q;
    logic [16:0] r2;
    r = rem_i;
    q = frac_i;
    for (int i = 0; i < FRAC_STEPS; i++) begin
      r2 = {r, 1'b0};
      if (r2 >= {1'b0, span_i}) begin
        r = 16'(r2 - {1'b0, span_i});
        q = {q[14:0], 1'b1};
      end else begin
        r = r2[15:0];
        q = {q[14:0], 1'b0};
      end
    end
    return {q, r};
  endfunction

  assign rdy[NST] = out_ready;
  for (genvar i = 0; i < NST; i++) begin : g_rdy
    assign rdy[i] = !v[i] || rdy[i+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_comb begin
    logic signed [16:0] d;
    logic signed [16:0] span_s;
    d      = {temperature[TEMP_W-1], temperature} - {rng.low[TEMP_W-1], rng.low};
    span_s = {1'b0, rng.span};
    if (!rng.span_ok) begin
      s1_mode_next = MODE_MID;
    end else if (d <= 17'sd0) begin
      s1_mode_next = MODE_ZERO;
    end else if (d >= span_s) begin
      s1_mode_next = MODE_FULL;
    end else begin
      s1_mode_next = MODE_DIV;
    end
    s1_a_next = {3'b000, d[15:0]} + {1'b0, d[15:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_mode <= s1_mode_next;
      s1_a    <= s1_a_next;
    end
  end

  always_comb begin
    logic [18:0] m1;
    logic [18:0] m2;
    logic [18:0] m3;
    logic [18:0] m4;
    logic [18:0] sel;
    m1 = {3'b000, rng.span};
    m2 = {2'b00, rng.span, 1'b0};
    m3 = m1 + m2;
    m4 = {1'b0, rng.span, 2'b00};
    if (s1_a >= m4) begin
      s2_seg_next = 3'd4;
      sel         = m4;
    end else if (s1_a >= m3) begin
      s2_seg_next = 3'd3;
      sel         = m3;
    end else if (s1_a >= m2) begin
      s2_seg_next = 3'd2;
      sel         = m2;
    end else if (s1_a >= m1) begin
      s2_seg_next = 3'd1;
      sel         = m1;
    end else begin
      s2_seg_next = 3'd0;
      sel         = '0;
    end
    s2_rem_next = 16'(s1_a - sel);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_mode <= s1_mode;
      s2_seg  <= s2_seg_next;
      s2_rem  <= s2_rem_next;
    end
  end

  for (genvar k = 0; k < FRAC_STAGES; k++) begin : g_frac
    mode_t            m_in;
    logic [SEG_W-1:0] seg_in;
    logic [15:0]      rem_in;
    logic [15:0]      frac_in;
    logic [31:0]      res;
    if (k == 0) begin : g_first
      assign m_in    = s2_mode;
      assign seg_in  = s2_seg;
      assign rem_in  = s2_rem;
      assign frac_in = '0;
    end else begin : g_rest
      assign m_in    = fr_mode[k-1];
      assign seg_in  = fr_seg[k-1];
      assign rem_in  = fr_rem[k-1];
      assign frac_in = fr_frac[k-1];
    end
    assign res = frac_step(rem_in, rng.span, frac_in);
    always_ff @(posedge clk) begin
      if (rdy[2+k]) begin
        fr_mode[k] <= m_in;
        fr_seg[k]  <= seg_in;
        fr_rem[k]  <= res[15:0];
        fr_frac[k] <= res[31:16];
      end
    end
  end

  // Substitute the fixed positions of clamped and degenerate samples.
  always_comb begin
    case (fr_mode[FRAC_STAGES-1])
      MODE_ZERO: begin
        out_pos.seg  = '0;
        out_pos.frac = '0;
      end
      MODE_FULL: begin
        out_pos.seg  = SEG_LAST;
        out_pos.frac = Q_ONE;
      end
      MODE_MID: begin
        out_pos.seg  = SEG_MID;
        out_pos.frac = Q_HALF;
      end
      default: begin
        out_pos.seg  = fr_seg[FRAC_STAGES-1];
        out_pos.frac = {1'b0, fr_frac[FRAC_STAGES-1]};
      end
    endcase
  end

  `TFC_ASSERT_IMP(a_seg_bound, v[1] && s2_mode == MODE_DIV, s2_seg <= SEG_LAST)
  `TFC_ASSERT_IMP(a_rem_bound, v[1] && s2_mode == MODE_DIV, s2_rem < rng.span)
  `TFC_ASSERT_NXT(a_take_in, in_valid && in_ready, v[0])
  `TFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pos))

endmodule
`default_nettype wire

// ===== hdl/tfc_colormap.sv =====
// Two-stage colormap: segment and fraction to packed RGB565.
`default_nettype none
module tfc_colormap import tfc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pos_t          in_pos,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [COLOR_W-1:0] rgb565
);

  logic [1:0] v;
  logic [2:0] rdy;

  logic [SEG_W-1:0] a_seg;
  logic [7:0]       a_up;
  logic [7:0]       a_dn;
  logic [11:0]      a_g;

  logic [7:0]   up_next;
  logic [7:0]   dn_next;
  logic [11:0]  g_next;
  logic [COLOR_W-1:0] rgb_next;

  assign rdy[2]    = out_ready;
  assign rdy[1]    = !v[1] || rdy[2];
  assign rdy[0]    = !v[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = v[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      if (rdy[1]) begin
        v[1] <= v[0];
      end
    end
  end

  // Stage A: 255 * f, 255 * (1 - f) and 255 * (base - 3f), each over 2^16.
  always_comb begin
    logic [FRAC_W:0] fc;
    logic [18:0]     f3;
    logic [19:0]     x;
    logic [24:0]     p_up;
    logic [24:0]     p_dn;
    logic [27:0]     p_g;
    fc   = Q_ONE - in_pos.frac;
    p_up = {in_pos.frac, 8'h00} - {8'h00, in_pos.frac};
    p_dn = {fc, 8'h00} - {8'h00, fc};
    f3   = {1'b0, in_pos.frac, 1'b0} + {2'b00, in_pos.frac};
    x    = ((in_pos.seg == 3'd3) ? X3_BASE : X4_BASE) - {1'b0, f3};
    p_g  = {x, 8'h00} - {8'h00, x};
    up_next = p_up[23:16];
    dn_next = p_dn[23:16];
    g_next  = p_g[27:16];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_seg <= in_pos.seg;
      a_up  <= up_next;
      a_dn  <= dn_next;
      a_g   <= g_next;
    end
  end

  // Stage B: finish the /10 and /5 by reciprocal, pick channels, pack.
  always_comb begin
    logic [24:0] p10;
    logic [21:0] p5;
    logic [7:0]  g_div;
    logic [7:0]  b_div;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    p10   = a_g * RECIP10;
    p5    = a_up * RECIP5;
    g_div = p10[23:16];
    b_div = {2'b00, p5[21:16]};
    case (a_seg)
      3'd0: begin
        r = 8'd0;   g = a_up;   b = 8'd255;
      end
      3'd1: begin
        r = 8'd0;   g = 8'd255; b = a_dn;
      end
      3'd2: begin
        r = a_up;   g = 8'd255; b = 8'd0;
      end
      3'd3: begin
        r = 8'd255; g = g_div;  b = 8'd0;
      end
      default: begin
        r = 8'd255; g = g_div;  b = b_div;
      end
    endcase
    rgb_next = {r[7:3], g[7:2], b[7:3]};
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      rgb565 <= rgb_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/thermal_false_color_rgb565.sv =====
// Top level of the thermal false-color mapper (temperature to RGB565).
//
// Usage:
//   samples : temperature stream in, signed 0.01 degree units.
//   colors  : RGB565 stream out, one item for every sample, in order.
//   cfg     : register writes; index 0 is range_low, index 1 is range_high.
//             Always ready. Write only while no sample is in flight.
// A sample at or below range_low maps to blue, at or above range_high to the
// top color (RGB 255/102/51), and an empty or inverted range maps every sample
// to the scale midpoint. Pipeline: nine register stages; the input register
// holds the sample, the divider spends one stage on the offset, one on the
// integer segment and four on four quotient bits each, and the colormap two
// stages. Throughput: one item per clock when nothing stalls; the loop is
// fully pipelined.
// Stall: when colors.ready is low the last stage holds its item; the stages
// behind it keep filling bubbles, so samples.ready drops only once every
// stage holds an item. Nothing is dropped or repeated.
// Reset (rst, synchronous): empty all stages, range_low = 2000,
// range_high = 3000.
`default_nettype none
module thermal_false_color_rgb565 import tfc_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  tfc_temp_if.sink    samples,
  tfc_color_if.source colors,
  tfc_cfg_if.sink     cfg
);

  logic signed [TEMP_W-1:0] range_low;
  logic signed [TEMP_W-1:0] range_high;
  range_t                   rng;

  logic                     v0;
  logic signed [TEMP_W-1:0] temp0;
  logic                     rdy0;

  logic div_in_ready;
  logic div_out_valid;
  logic map_in_ready;
  pos_t div_pos;

  // Configuration: take every write, ignore unknown indexes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= RANGE_LOW_RESET;
      range_high <= RANGE_HIGH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_RANGE_LOW:  range_low  <= cfg.data;
        CFG_RANGE_HIGH: range_high <= cfg.data;
        default: ;
      endcase
    end
  end

  // Span of the scale; the range is usable only when high exceeds low.
  always_comb begin
    logic [TEMP_W:0] span;
    span        = {range_high[TEMP_W-1], range_high} - {range_low[TEMP_W-1], range_low};
    rng.low     = range_low;
    rng.span    = span[TEMP_W-1:0];
    rng.span_ok = !span[TEMP_W] && (span != '0);
  end

  // Input register: hold the sample until the divider takes it.
  assign rdy0          = !v0 || div_in_ready;
  assign samples.ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      temp0 <= samples.temperature;
    end
  end

  tfc_divider u_divider (
    .clk         (clk),
    .rst         (rst),
    .rng         (rng),
    .in_valid    (v0),
    .in_ready    (div_in_ready),
    .temperature (temp0),
    .out_valid   (div_out_valid),
    .out_ready   (map_in_ready),
    .out_pos     (div_pos)
  );

  tfc_colormap u_colormap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_out_valid),
    .in_ready  (map_in_ready),
    .in_pos    (div_pos),
    .out_valid (colors.valid),
    .out_ready (colors.ready),
    .rgb565    (colors.rgb565)
  );

endmodule
`default_nettype wire
